/* hdl/scm_pkg.sv */
// ----------------------------------------------------------------------------
// scm_pkg
// Shared types, constants and hash helpers for the sampled count-min update.
// ----------------------------------------------------------------------------
package scm_pkg;

	localparam int unsigned RowsDef       = 4;
	localparam int unsigned ColumnsDef    = 1024;
	localparam int unsigned GeoTableDef   = 256;

	localparam logic [31:0] Pr1 = 32'd2654435761;
	localparam logic [31:0] Pr2 = 32'd2246822519;
	localparam logic [31:0] Pr3 = 32'd3266489917;
	localparam logic [31:0] Pr4 = 32'd668265263;

	localparam logic [1:0] OpUpdate = 2'd0;
	localparam logic [1:0] OpLoad   = 2'd1;
	localparam logic [1:0] OpRead   = 2'd2;

	localparam logic [1:0] StSkipped = 2'd0;
	localparam logic [1:0] StUpdated = 2'd1;
	localparam logic [1:0] StZeroGeo = 2'd2;
	localparam logic [1:0] StDone    = 2'd3;

	typedef struct packed {
		logic [1:0]  op;
		logic [31:0] src_ip;
		logic [31:0] dst_ip;
		logic [15:0] sport;
		logic [15:0] dport;
		logic [7:0]  proto;
		logic [7:0]  geo_slot;
		logic [15:0] geo_value;
		logic [1:0]  read_row;
		logic [9:0]  read_column;
	} scm_in_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [2:0]  rows_touched;
		logic [31:0] counter_value;
	} scm_out_t;

	function automatic logic [31:0] row_seed(input logic [5:0] r);
		logic [31:0] s;
		begin
			unique case (r)
				6'd0:  s = 32'hec5853;    6'd1:  s = 32'hec5859;
				6'd2:  s = 32'hec5861;    6'd3:  s = 32'hec587f;
				6'd4:  s = 32'hec58a7;    6'd5:  s = 32'hec58b3;
				6'd6:  s = 32'hec58c7;    6'd7:  s = 32'hec58d1;
				6'd8:  s = 32'hec58531;   6'd9:  s = 32'hec58592;
				6'd10: s = 32'hec58613;   6'd11: s = 32'hec587f4;
				6'd12: s = 32'hec58a75;   6'd13: s = 32'hec58b36;
				6'd14: s = 32'hec58c77;   6'd15: s = 32'hec58d18;
				6'd16: s = 32'hec58539;   6'd17: s = 32'hec58510;
				6'd18: s = 32'hec58611;   6'd19: s = 32'hec58712;
				6'd20: s = 32'hec58a13;   6'd21: s = 32'hec58b14;
				6'd22: s = 32'hec58c15;   6'd23: s = 32'hec58d16;
				6'd24: s = 32'hec58521;   6'd25: s = 32'hec58522;
				6'd26: s = 32'hec58623;   6'd27: s = 32'hec58724;
				6'd28: s = 32'hec58a25;   6'd29: s = 32'hec58b26;
				6'd30: s = 32'hec58c27;   6'd31: s = 32'hec58d28;
				6'd32: s = 32'hec58541;   6'd33: s = 32'hec58542;
				6'd34: s = 32'hec58643;   6'd35: s = 32'hec58744;
				6'd36: s = 32'hec58a45;   6'd37: s = 32'hec58b46;
				6'd38: s = 32'hec58c47;   6'd39: s = 32'hec58d48;
				6'd40: s = 32'hec58551;   6'd41: s = 32'hec58552;
				6'd42: s = 32'hec58653;   6'd43: s = 32'hec58754;
				6'd44: s = 32'hec58a55;   6'd45: s = 32'hec58b56;
				6'd46: s = 32'hec58c57;   6'd47: s = 32'hec58d58;
				6'd48: s = 32'hec58561;   6'd49: s = 32'hec58563;
				6'd50: s = 32'hec58663;   6'd51: s = 32'hec58764;
				6'd52: s = 32'hec58a65;   6'd53: s = 32'hec58b66;
				6'd54: s = 32'hec58c67;   6'd55: s = 32'hec58d68;
				6'd56: s = 32'hec58571;   6'd57: s = 32'hec58572;
				6'd58: s = 32'hec58673;   6'd59: s = 32'hec58774;
				6'd60: s = 32'hec58a75;   6'd61: s = 32'hec58b76;
				6'd62: s = 32'hec58c77;   6'd63: s = 32'hec58d78;
				default: s = 32'd0;
			endcase
			return s;
		end
	endfunction

	function automatic logic [31:0] rotl(input logic [31:0] x, input int unsigned r);
		return (x << r) | (x >> (32 - r));
	endfunction

	function automatic logic [31:0] bswap(input logic [31:0] x);
		return {x[7:0], x[15:8], x[23:16], x[31:24]};
	endfunction

endpackage

/* hdl/sampled_countmin_update_unit.sv */
// ----------------------------------------------------------------------------
// sampled_countmin_update_unit
// Count-min sketch update with geometric row sampling.
// ----------------------------------------------------------------------------
// Input channel in_valid/in_ready carries one command beat: packet update,
// geometric table load or counter read. Output channel out_valid/out_ready
// returns one result beat per command.
// One command is worked at a time. A packet update works the rows it
// touches one after another, each through the shared hash multiplier and
// the counter read-modify-write.
// After reset the counter memory is cleared, one entry a cycle, until all
// ROWS*COLUMNS_PER_ROW entries (4096 by default) are zero; in_ready stays
// low meanwhile.
// The geometric table must be loaded before packets are sent.
// When the receiver stalls the result is held and no new beat is taken.
// ----------------------------------------------------------------------------
module sampled_countmin_update_unit #(
	parameter int unsigned ROWS            = scm_pkg::RowsDef,
	parameter int unsigned COLUMNS_PER_ROW = scm_pkg::ColumnsDef,
	parameter int unsigned GEO_TABLE_SIZE  = scm_pkg::GeoTableDef
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  scm_pkg::scm_in_t  in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output scm_pkg::scm_out_t out_data
);
	import scm_pkg::*;

	scm_core #(
		.ROWS           (ROWS),
		.COLUMNS_PER_ROW(COLUMNS_PER_ROW),
		.GEO_TABLE_SIZE (GEO_TABLE_SIZE)
	) u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

endmodule

/* hdl/scm_hash.sv */
// ----------------------------------------------------------------------------
// scm_hash
// Multi-cycle xxh32 of the 16-byte flow key, one 32x32 multiply per cycle.
// ----------------------------------------------------------------------------
module scm_hash (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] seed,
	input  logic [127:0] key,
	output logic        done,
	output logic [31:0] hash
);
	import scm_pkg::*;

	// step sequence: 4 lane mults, 4 lane rounds (fold with the last), 2 finalise mults
	typedef enum logic [1:0] {
		H_IDLE, H_LANE, H_FIN
	} hstate_t;

	hstate_t     state_q;
	logic [3:0]  step_q;
	logic [31:0] acc_q [4];
	logic [31:0] tmp_q;
	logic [31:0] h_q;
	logic [31:0] lane;
	logic [31:0] prod_a, prod_b, prod;
	logic [31:0] fold;
	logic [31:0] hx;

	always_comb begin
		unique case (step_q[1:0])
			2'd0: lane = bswap(key[127:96]);
			2'd1: lane = bswap(key[95:64]);
			2'd2: lane = bswap(key[63:32]);
			default: lane = bswap(key[31:0]);
		endcase
	end

	// shared multiplier operand selection
	always_comb begin
		prod_a = lane;
		prod_b = Pr2;
		hx     = h_q;
		if (state_q == H_LANE && step_q[2]) begin
			prod_a = rotl(tmp_q, 13);
			prod_b = Pr1;
		end else if (state_q == H_FIN) begin
			if (step_q[0] == 1'b0) begin
				hx     = h_q ^ (h_q >> 15);
				prod_b = Pr2;
			end else begin
				hx     = h_q ^ (h_q >> 13);
				prod_b = Pr3;
			end
			prod_a = hx;
		end
		prod = prod_a * prod_b;
	end

	// used on the last lane round, where the fourth lane is still on the multiplier
	assign fold = rotl(acc_q[0], 1) + rotl(acc_q[1], 7) + rotl(acc_q[2], 12)
		+ rotl(prod, 18) + 32'd16;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= H_IDLE;
			step_q  <= '0;
			done    <= 1'b0;
		end else begin
			done <= 1'b0;
			unique case (state_q)
				H_IDLE: begin
					if (start) begin
						acc_q[0] <= seed + Pr1 + Pr2;
						acc_q[1] <= seed + Pr2;
						acc_q[2] <= seed;
						acc_q[3] <= seed - Pr1;
						step_q   <= '0;
						state_q  <= H_LANE;
					end
				end
				H_LANE: begin
					if (!step_q[2]) begin
						// acc + lane*PR2, hold for the round multiply
						tmp_q  <= acc_q[step_q[1:0]] + prod;
						step_q <= step_q | 4'd4;
					end else begin
						acc_q[step_q[1:0]] <= prod;
						if (step_q[1:0] == 2'd3) begin
							h_q     <= fold;
							step_q  <= '0;
							state_q <= H_FIN;
						end else begin
							step_q <= {2'b00, step_q[1:0] + 2'd1};
						end
					end
				end
				H_FIN: begin
					h_q <= prod;
					if (step_q[0]) begin
						hash    <= prod ^ (prod >> 16);
						done    <= 1'b1;
						state_q <= H_IDLE;
					end
					step_q <= step_q + 4'd1;
				end
				default: state_q <= H_IDLE;
			endcase
		end
	end

endmodule

/* hdl/scm_core.sv */
// ----------------------------------------------------------------------------
// scm_core
// Sequencer with the geometric table and counter memories; read-modify-write.
// ----------------------------------------------------------------------------
module scm_core #(
	parameter int unsigned ROWS            = scm_pkg::RowsDef,
	parameter int unsigned COLUMNS_PER_ROW = scm_pkg::ColumnsDef,
	parameter int unsigned GEO_TABLE_SIZE  = scm_pkg::GeoTableDef
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  scm_pkg::scm_in_t in_data,
	output logic            out_valid,
	input  logic            out_ready,
	output scm_pkg::scm_out_t out_data
);
	import scm_pkg::*;

	localparam int unsigned RW    = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int unsigned CW    = $clog2(COLUMNS_PER_ROW);
	localparam int unsigned GW    = $clog2(GEO_TABLE_SIZE);
	localparam int unsigned AW    = RW + CW;
	localparam int unsigned DEPTH = ROWS * COLUMNS_PER_ROW;
	localparam int unsigned TW    = $clog2(ROWS + 1);
	localparam logic [31:0] ROWS32 = 32'(ROWS);

	typedef enum logic [3:0] {
		S_IDLE, S_CLEAR, S_HASH, S_HWAIT, S_RD, S_WR, S_GEO, S_ADV, S_READ, S_RDONE, S_OUT
	} state_t;

	state_t          state_q;
	logic [31:0]     skip_q;
	logic [GW-1:0]   gptr_q;
	logic [31:0]     row_q;
	logic [TW-1:0]   touched_q;
	logic [AW-1:0]   addr_q;
	logic [AW:0]     clr_q;
	scm_in_t         item_q;

	logic [15:0]     geo_mem [GEO_TABLE_SIZE];
	logic [31:0]     cnt_mem [DEPTH];
	logic [15:0]     geo_rd;
	logic [31:0]     cnt_rd;
	logic            cnt_we;
	logic [AW-1:0]   cnt_wa;
	logic [31:0]     cnt_wd;
	logic [AW-1:0]   cnt_ra;

	logic            h_start, h_done;
	logic [31:0]     h_val;
	logic [RW-1:0]   row_idx;
	logic [5:0]      seed_idx;
	logic [GW-1:0]   gptr_nx;
	logic [32:0]     row_sum;

	assign row_idx  = row_q[RW-1:0];
	assign seed_idx = 6'(row_q);
	assign gptr_nx  = gptr_q + GW'(1);
	assign row_sum  = {1'b0, row_q} + {17'd0, geo_rd};

	scm_hash u_hash (
		.clk   (clk),
		.arst_n(arst_n),
		.start (h_start),
		.seed  (row_seed(seed_idx)),
		.key   ({item_q.src_ip, item_q.dst_ip, item_q.sport, item_q.dport,
			item_q.proto, 24'd0}),
		.done  (h_done),
		.hash  (h_val)
	);

	assign h_start  = (state_q == S_HASH);
	assign in_ready = (state_q == S_IDLE);

	// memories
	always_ff @(posedge clk) begin
		if (cnt_we) cnt_mem[cnt_wa] <= cnt_wd;
		cnt_rd <= cnt_mem[cnt_ra];
		if (state_q == S_IDLE && in_valid && in_data.op == OpLoad)
			geo_mem[in_data.geo_slot[GW-1:0]] <= in_data.geo_value;
		geo_rd <= geo_mem[gptr_q];
	end

	always_comb begin
		cnt_we = 1'b0;
		cnt_wa = addr_q;
		cnt_wd = cnt_rd + ROWS32;
		cnt_ra = addr_q;
		if (state_q == S_CLEAR) begin
			cnt_we = 1'b1;
			cnt_wa = clr_q[AW-1:0];
			cnt_wd = '0;
		end else if (state_q == S_WR) begin
			cnt_we = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_CLEAR;
			clr_q     <= '0;
			skip_q    <= '0;
			gptr_q    <= '0;
			touched_q <= '0;
			out_valid <= 1'b0;
			out_data  <= '0;
		end else begin
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == (AW+1)'(DEPTH - 1)) state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (in_valid) begin
						item_q    <= in_data;
						touched_q <= '0;
						out_data  <= '{status: (in_data.op == OpUpdate && skip_q >= ROWS32)
							? StSkipped : StDone, rows_touched: 3'd0, counter_value: 32'd0};
						unique case (in_data.op)
							OpUpdate: begin
								if (skip_q >= ROWS32) begin
									skip_q  <= skip_q - ROWS32;
									state_q <= S_OUT;
								end else begin
									row_q   <= skip_q;
									state_q <= S_HASH;
								end
							end
							OpRead: begin
								addr_q  <= AW'(in_data.read_row) * AW'(COLUMNS_PER_ROW)
									+ AW'(in_data.read_column);
								state_q <= ((32'(in_data.read_row) < ROWS32) &&
									(32'(in_data.read_column) < 32'(COLUMNS_PER_ROW)))
									? S_READ : S_OUT;
							end
							default: state_q <= S_OUT;
						endcase
					end
				end
				S_HASH: state_q <= S_HWAIT;
				S_HWAIT: begin
					if (h_done) begin
						addr_q  <= {row_idx, h_val[CW-1:0]};
						state_q <= S_RD;
					end
				end
				S_RD: begin
					gptr_q  <= gptr_nx;
					state_q <= S_WR;
				end
				S_WR: begin
					touched_q <= touched_q + TW'(1);
					state_q   <= S_GEO;
				end
				S_GEO: state_q <= S_ADV;
				S_ADV: begin
					row_q <= row_sum[31:0];
					if (row_sum[32] || row_sum[31:0] >= ROWS32 ||
						32'(touched_q) >= ROWS32) begin
						out_data <= '{status: (geo_rd != 16'd0) ? StUpdated : StZeroGeo,
							rows_touched: 3'(touched_q), counter_value: 32'd0};
						if (geo_rd != 16'd0)
							skip_q <= {16'd0, geo_rd} - 32'd1;
						state_q <= S_OUT;
					end else begin
						state_q <= S_HASH;
					end
				end
				S_READ: state_q <= S_RDONE;
				S_RDONE: begin
					out_data <= '{status: StDone, rows_touched: 3'd0, counter_value: cnt_rd};
					state_q  <= S_OUT;
				end
				S_OUT: begin
					out_valid <= 1'b1;
					if (out_valid && out_ready) begin
						out_valid <= 1'b0;
						state_q   <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WR) |-> $past(state_q) == S_RD)
		else $error("counter write without read");
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> state_q == S_OUT)
		else $error("result shown outside output state");
	assert property (@(posedge clk) disable iff (!arst_n)
		32'(touched_q) <= ROWS32 || state_q == S_IDLE)
		else $error("too many row updates");

endmodule
